>>> sv/piecewise_linear_series_eval_assert.svh
// Assertion macros for the piecewise linear series evaluator.
// Used by modules that include this header; expects clk and rst_n in scope.
`ifndef PIECEWISE_LINEAR_SERIES_EVAL_ASSERT_SVH
`define PIECEWISE_LINEAR_SERIES_EVAL_ASSERT_SVH

// Property that must hold at every clock edge outside reset
`define PLSE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define PLSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/plse_pkg.sv
// Shared types and constants for the piecewise linear series evaluator.
// No dependencies.
package plse_pkg;

    localparam int MAX_SEGMENTS = 16;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

    // Operation codes
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_EVAL   = 1'b1;

    // Result status codes
    localparam logic [1:0] STAT_EVALUATED = 2'd0;
    localparam logic [1:0] STAT_APPENDED  = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_SATURATED = 2'd3;

    // One stored segment, all fields signed Q16.16
    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] slope;
        logic signed [31:0] intercept;
    } seg_t;

    // Fixed table entry 0: flat zero segment starting at the most negative x
    localparam seg_t SEG_FIRST = '{
        start_x:   32'sh8000_0000,
        start_y:   32'sh0000_0000,
        slope:     32'sh0000_0000,
        intercept: 32'sh0000_0000
    };

endpackage

>>> sv/piecewise_linear_series_eval.sv
// Top level of the piecewise linear series evaluator: sequencer, output register.
// Depends on plse_pkg, plse_seg_table, plse_arith and the assertion header.
//
// An append transaction stores a segment at the end of the table unless the
// table is full, and its result is ready on the next edge. An evaluate
// transaction scans the table one entry per cycle through the table's single
// read port, stopping at the first entry whose start lies above x or at the
// last stored entry, then passes through a multiply state and an add and
// clamp state before the result is loaded; at most the segment count of
// entries is examined, up to 16 with a full table. A new transaction is
// taken once the sequencer is idle and the output register is empty or
// being emptied in that cycle.
module piecewise_linear_series_eval (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               operation,
    input  logic signed [31:0] x_value,
    input  logic signed [31:0] seg_start_x,
    input  logic signed [31:0] seg_start_y,
    input  logic signed [31:0] seg_slope,
    input  logic signed [31:0] seg_intercept,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] result_value,
    output logic [1:0]         status
);
    import plse_pkg::*;
    `include "piecewise_linear_series_eval_assert.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_ADD
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic signed [31:0] x_reg, x_next;
    seg_t               sel_reg, sel_next;
    logic signed [32:0] dx_reg, dx_next;
    logic signed [64:0] prod_reg, prod_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] result_reg, result_next;
    logic [1:0]         status_reg, status_next;

    logic               in_accept;
    logic               tbl_wr_en;
    logic [IDX_W-1:0]   tbl_rd_addr;
    seg_t               tbl_wr_data;
    seg_t               tbl_rd_data;
    logic signed [32:0] alu_dx;
    logic               alu_ge;
    logic signed [64:0] alu_prod;
    logic signed [31:0] alu_sum;
    logic               alu_sat;

    // Handshake
    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_accept = in_valid && !in_stall;

    // Table access
    assign tbl_wr_en   = in_accept && (operation == OP_APPEND) &&
                         (count_reg != CNT_W'(MAX_SEGMENTS));
    assign tbl_wr_data = '{start_x: seg_start_x, start_y: seg_start_y,
                           slope: seg_slope, intercept: seg_intercept};
    assign tbl_rd_addr = (state_reg == S_SCAN) ? (chk_idx_reg + IDX_W'(1)) : '0;

    plse_seg_table u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (tbl_wr_data),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    plse_arith u_arith (
        .x         (x_reg),
        .start_x   (tbl_rd_data.start_x),
        .slope     (sel_reg.slope),
        .dx_in     (dx_reg),
        .prod_in   (prod_reg),
        .intercept (sel_reg.intercept),
        .start_y   (sel_reg.start_y),
        .dx        (alu_dx),
        .x_ge      (alu_ge),
        .prod      (alu_prod),
        .sum       (alu_sum),
        .sat       (alu_sat)
    );

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        chk_idx_next   = chk_idx_reg;
        x_next         = x_reg;
        sel_next       = sel_reg;
        dx_next        = dx_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && out_stall;
        result_next    = result_reg;
        status_next    = status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (operation == OP_APPEND)
                    begin
                        out_valid_next = 1'b1;
                        result_next    = '0;
                        if (count_reg == CNT_W'(MAX_SEGMENTS))
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            count_next  = count_reg + CNT_W'(1);
                            status_next = STAT_APPENDED;
                        end
                    end
                    else
                    begin
                        x_next       = x_value;
                        chk_idx_next = '0;
                        state_next   = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // Entry chk_idx is on the read port this cycle
                if (alu_ge)
                begin
                    sel_next = tbl_rd_data;
                    dx_next  = alu_dx;
                    if (CNT_W'(chk_idx_reg) == count_reg - CNT_W'(1))
                    begin
                        state_next = S_MUL;
                    end
                    else
                    begin
                        chk_idx_next = chk_idx_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = alu_prod;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                result_next    = alu_sum;
                status_next    = alu_sat ? STAT_SATURATED : STAT_EVALUATED;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= CNT_W'(1);
            chk_idx_reg   <= '0;
            x_reg         <= '0;
            sel_reg       <= SEG_FIRST;
            dx_reg        <= '0;
            prod_reg      <= '0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
            status_reg    <= STAT_EVALUATED;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chk_idx_reg   <= chk_idx_next;
            x_reg         <= x_next;
            sel_reg       <= sel_next;
            dx_reg        <= dx_next;
            prod_reg      <= prod_next;
            out_valid_reg <= out_valid_next;
            result_reg    <= result_next;
            status_reg    <= status_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;
    assign status       = status_reg;

    // Checks
    `PLSE_ASSERT(a_count_range,
        (count_reg >= CNT_W'(1)) && (count_reg <= CNT_W'(MAX_SEGMENTS)),
        "segment count out of range")
    `PLSE_ASSERT(a_scan_in_table,
        (state_reg != S_SCAN) || (CNT_W'(chk_idx_reg) < count_reg),
        "scan index beyond stored segments")
    `PLSE_ASSERT_NEXT(a_append_counts,
        in_accept && (operation == OP_APPEND) && (count_reg != CNT_W'(MAX_SEGMENTS)),
        count_reg == $past(count_reg) + CNT_W'(1),
        "append did not advance segment count")
    `PLSE_ASSERT_NEXT(a_eval_starts_scan,
        in_accept && (operation == OP_EVAL),
        (state_reg == S_SCAN) && (chk_idx_reg == '0),
        "evaluate did not start scan at entry 0")
    `PLSE_ASSERT_NEXT(a_add_loads_output,
        state_reg == S_ADD,
        out_valid_reg && (state_reg == S_IDLE),
        "evaluate result not loaded after add")

endmodule

>>> sv/plse_seg_table.sv
// Segment table: one write port, one registered read port.
// Depends on plse_pkg. Entry 0 is the fixed first segment and is never stored.
module plse_seg_table (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [plse_pkg::IDX_W-1:0] wr_addr,
    input  plse_pkg::seg_t         wr_data,
    input  logic [plse_pkg::IDX_W-1:0] rd_addr,
    output plse_pkg::seg_t         rd_data
);
    import plse_pkg::*;

    seg_t mem [MAX_SEGMENTS];
    seg_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, entry 0 comes from the constant
    always_ff @(posedge clk)
    begin
        if (rd_addr == '0)
        begin
            rd_data_reg <= SEG_FIRST;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/plse_arith.sv
// Shared arithmetic unit: offset subtract and compare, slope multiply,
// and the final add with saturation. Depends on plse_pkg.
module plse_arith (
    input  logic signed [31:0] x,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] slope,
    input  logic signed [32:0] dx_in,
    input  logic signed [64:0] prod_in,
    input  logic signed [31:0] intercept,
    input  logic signed [31:0] start_y,
    output logic signed [32:0] dx,
    output logic               x_ge,
    output logic signed [64:0] prod,
    output logic signed [31:0] sum,
    output logic               sat
);
    import plse_pkg::*;

    logic signed [48:0] prod_sh;
    logic signed [50:0] sum_wide;

    // Exact 33-bit offset; its sign is the compare result
    assign dx   = {x[31], x} - {start_x[31], start_x};
    assign x_ge = ~dx[32];

    // Exact Q33.32 product
    assign prod = 65'(slope) * 65'(dx_in);

    // Floor shift to 16 fraction bits (Q33.16), then exact sum
    assign prod_sh  = prod_in[64:16];
    assign sum_wide = {{2{prod_sh[48]}}, prod_sh}
                    + {{19{intercept[31]}}, intercept}
                    + {{19{start_y[31]}}, start_y};

    // Clamp to the signed 32-bit range
    always_comb
    begin
        sat = (sum_wide[50:31] != {20{1'b0}}) && (sum_wide[50:31] != {20{1'b1}});
        if (!sat)
        begin
            sum = sum_wide[31:0];
        end
        else if (sum_wide[50])
        begin
            sum = 32'sh8000_0000;
        end
        else
        begin
            sum = 32'sh7FFF_FFFF;
        end
    end

endmodule
